/* design/dtn_pkg.sv */
// dtn_pkg: shared types and constants for the decimal text parser.
// Used by dtn_front, dtn_back and decimal_text_to_number_unit. No dependencies.
package dtn_pkg;

    localparam int MANT_FIELD_W = 60;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef enum logic [2:0] {
        TK_SPACE = 3'd0,
        TK_DIGIT = 3'd1,
        TK_PLUS  = 3'd2,
        TK_MINUS = 3'd3,
        TK_POINT = 3'd4,
        TK_OTHER = 3'd5,
        TK_END   = 3'd6
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
    } tok_t;

    typedef enum logic [1:0] {
        KIND_NUM = 2'd0,
        KIND_NAN = 2'd1,
        KIND_END = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic                    negative;
        logic [MANT_FIELD_W-1:0] mantissa;
        logic [4:0]              frac_digits;
        logic                    overflow;
        logic                    last;
    } res_t;

endpackage

/* design/decimal_text_to_number_unit.sv */
// decimal_text_to_number_unit: streaming ASCII decimal number parser.
// Instantiates dtn_front and dtn_back; depends on dtn_pkg.
//
// Usage:
//   Input channel s_*: one character byte per word (s_char_code), or an
//   end-of-stream marker (s_end_of_input = 1, byte ignored).
//   Result channel m_*: words of kind number (sign, mantissa, count of
//   fraction digits, overflow), not-a-number or end. m_last marks the final
//   word caused by one input word; one input gives zero, one or two words.
//   A result word passes the token queue and then the output queue, both
//   registered, before it is offered on the result port.
//   Throughput: one character per cycle while s_ready is high; the digit step
//   (acc*10 + d, one wide add and carry check) is combinational. An input
//   that yields two words offers them on the result port one after the other.
//   A two-entry token queue and a four-entry result queue keep s_ready high
//   while results wait; when m_ready is held low, words flow until the result
//   queue holds three or four words, then s_ready drops once two more wait.
//   Reset (aresetn low, synchronous) empties both queues and discards any
//   number in progress.
module decimal_text_to_number_unit import dtn_pkg::*; #(
    parameter int MANTISSA_BITS   = 60,
    parameter int MAX_FRAC_DIGITS = 18
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_char_code,
    input  logic                    s_end_of_input,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_kind,
    output logic                    m_negative,
    output logic [MANT_FIELD_W-1:0] m_mantissa,
    output logic [4:0]              m_frac_digits,
    output logic                    m_overflow,
    output logic                    m_last
);

    logic tok_valid;
    logic tok_ready;
    tok_t tok;
    res_t m_res;

    dtn_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_end_of_input (s_end_of_input),
        .tok_valid      (tok_valid),
        .tok_ready      (tok_ready),
        .tok            (tok)
    );

    dtn_back #(
        .MANTISSA_BITS   (MANTISSA_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_kind        = m_res.kind;
    assign m_negative    = m_res.negative;
    assign m_mantissa    = m_res.mantissa;
    assign m_frac_digits = m_res.frac_digits;
    assign m_overflow    = m_res.overflow;
    assign m_last        = m_res.last;

endmodule

/* design/dtn_front.sv */
// dtn_front: classifies each input byte into a token and holds it in a
// two-entry queue for the back end. Depends on dtn_pkg.
module dtn_front import dtn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_input,
    output logic       tok_valid,
    input  logic       tok_ready,
    output tok_t       tok
);

    tok_t       q_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    tok_t       cls_tok;
    logic       push, pop;

    always_comb begin
        cls_tok = '{cls: TK_OTHER, digit: 4'd0};
        if (s_end_of_input) begin
            cls_tok.cls = TK_END;
        end else begin
            case (s_char_code) inside
                [CH_TAB:CH_CR], CH_SPACE: cls_tok.cls = TK_SPACE;
                [CH_ZERO:CH_NINE]: begin
                    cls_tok.cls   = TK_DIGIT;
                    cls_tok.digit = 4'(s_char_code - CH_ZERO);
                end
                CH_PLUS:  cls_tok.cls = TK_PLUS;
                CH_MINUS: cls_tok.cls = TK_MINUS;
                CH_POINT: cls_tok.cls = TK_POINT;
                default:  cls_tok.cls = TK_OTHER;
            endcase
        end
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign tok_valid = (cnt_reg != 2'd0);
    assign tok       = q_reg[rd_reg];
    assign push      = s_valid && s_ready;
    assign pop       = tok_valid && tok_ready;

    always_comb begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= cls_tok;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("token queue count out of range");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_valid && tok.cls == TK_DIGIT |-> tok.digit <= DIGIT_MAX)
        else $error("digit token out of range");

    a_nondigit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_valid && tok.cls != TK_DIGIT |-> tok.digit == 4'd0)
        else $error("non-digit token carries a digit");

endmodule

/* design/dtn_back.sv */
// dtn_back: number state machine; consumes tokens and writes up to two
// result words per token into a four-entry output queue. Depends on dtn_pkg.
module dtn_back import dtn_pkg::*; #(
    parameter int MANTISSA_BITS   = 60,
    parameter int MAX_FRAC_DIGITS = 18
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       tok_valid,
    output logic       tok_ready,
    input  tok_t       tok,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_res
);

    localparam int         MW       = MANTISSA_BITS;
    localparam logic [4:0] FRAC_MAX = 5'(MAX_FRAC_DIGITS);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_INT  = 3'b010,
        PH_FRAC = 3'b100
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic [MW-1:0]     acc_reg, acc_next;
    logic [4:0]        fc_reg, fc_next;
    logic              sat_reg, sat_next;

    res_t              q_reg [4];
    logic [1:0]        wr_reg, wr_next;
    logic [1:0]        rd_reg, rd_next;
    logic [2:0]        cnt_reg, cnt_next;

    logic [MW+3:0]     wide;
    logic [MANT_FIELD_W-1:0] mant_out;
    logic              active;
    logic              tok_pop, m_pop;
    res_t              r0, r1, num_res, nan_res, end_res;
    logic [1:0]        n_res;

    generate
        if (MW >= MANT_FIELD_W) begin : g_trunc
            assign mant_out = acc_reg[MANT_FIELD_W-1:0];
        end else begin : g_ext
            assign mant_out = {{(MANT_FIELD_W-MW){1'b0}}, acc_reg};
        end
    endgenerate

    // acc*10 + d
    assign wide = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                + {{MW{1'b0}}, tok.digit};

    assign active  = (phase_reg == PH_INT) || (phase_reg == PH_FRAC);
    assign num_res = '{kind: KIND_NUM, negative: neg_reg, mantissa: mant_out,
                       frac_digits: fc_reg, overflow: sat_reg, last: 1'b0};
    assign nan_res = '{kind: KIND_NAN, default: '0};
    assign end_res = '{kind: KIND_END, default: '0};

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        fc_next    = fc_reg;
        sat_next   = sat_reg;
        r0         = '0;
        r1         = '0;
        n_res      = 2'd0;
        if (tok.cls == TK_END) begin
            if (active) begin
                r0    = num_res;
                r1    = end_res;
                n_res = 2'd2;
            end else begin
                r0    = end_res;
                n_res = 2'd1;
            end
            phase_next = PH_IDLE;
            neg_next   = 1'b0;
            acc_next   = '0;
            fc_next    = 5'd0;
            sat_next   = 1'b0;
        end else if (active && tok.cls == TK_DIGIT) begin
            if (!sat_reg) begin
                if (phase_reg == PH_FRAC && fc_reg >= FRAC_MAX) begin
                    sat_next = 1'b1;
                end else if (|wide[MW+3:MW]) begin
                    acc_next = '1;
                    sat_next = 1'b1;
                end else begin
                    acc_next = wide[MW-1:0];
                    if (phase_reg == PH_FRAC) begin
                        fc_next = fc_reg + 5'd1;
                    end
                end
            end
        end else if (phase_reg == PH_INT && tok.cls == TK_POINT) begin
            phase_next = PH_FRAC;
        end else begin
            // terminator: flush, then treat the byte as a fresh start
            if (active) begin
                r0    = num_res;
                n_res = 2'd1;
            end
            phase_next = PH_IDLE;
            neg_next   = 1'b0;
            acc_next   = '0;
            fc_next    = 5'd0;
            sat_next   = 1'b0;
            case (tok.cls)
                TK_DIGIT: begin
                    phase_next = PH_INT;
                    acc_next   = {{(MW-4){1'b0}}, tok.digit};
                end
                TK_PLUS:  phase_next = PH_INT;
                TK_MINUS: begin
                    phase_next = PH_INT;
                    neg_next   = 1'b1;
                end
                TK_POINT: phase_next = PH_FRAC;
                TK_OTHER: begin
                    if (active) begin
                        r1    = nan_res;
                        n_res = 2'd2;
                    end else begin
                        r0    = nan_res;
                        n_res = 2'd1;
                    end
                end
                default: ;
            endcase
        end
        if (n_res == 2'd2) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
    end

    // output queue
    assign tok_ready = (cnt_reg <= 3'd2);
    assign tok_pop   = tok_valid && tok_ready;
    assign m_valid   = (cnt_reg != 3'd0);
    assign m_res     = q_reg[rd_reg];
    assign m_pop     = m_valid && m_ready;

    always_comb begin
        wr_next  = tok_pop ? wr_reg + n_res : wr_reg;
        rd_next  = m_pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + (tok_pop ? {1'b0, n_res} : 3'd0) - 3'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            fc_reg    <= 5'd0;
            sat_reg   <= 1'b0;
            wr_reg    <= 2'd0;
            rd_reg    <= 2'd0;
            cnt_reg   <= 3'd0;
        end else begin
            if (tok_pop) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                fc_reg    <= fc_next;
                sat_reg   <= sat_next;
            end
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_pop && n_res != 2'd0) begin
            q_reg[wr_reg] <= r0;
        end
        if (tok_pop && n_res == 2'd2) begin
            q_reg[wr_reg + 2'd1] <= r1;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("result queue overrun");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_pop && tok.cls == TK_END |=> phase_reg == PH_IDLE && acc_reg == '0)
        else $error("end of input left number state");

    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fc_reg <= FRAC_MAX)
        else $error("fraction digit count beyond limit");

    a_plain_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.kind != KIND_NUM |->
            !m_res.negative && m_res.mantissa == '0 && m_res.frac_digits == 5'd0
            && !m_res.overflow)
        else $error("non-number word carries number fields");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.kind == KIND_END |-> m_res.last)
        else $error("end word not marked last");

endmodule

/* tb/sv/tb_decimal_text_to_number_unit.sv */
// Testbench for decimal_text_to_number_unit: feeds character words and end markers,
// predicts the parsed number words in step with the input and checks every result.
// Depends on dtn_pkg and the RTL of the unit only.
`timescale 1ns / 100ps

module tb_decimal_text_to_number_unit import dtn_pkg::*;;

    localparam int MANT_BITS = 60;
    localparam int MAX_FRAC  = 18;
    localparam logic [63:0] MANT_MAX = (64'd1 << MANT_BITS) - 64'd1;
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;
    localparam int TOTAL_WORDS = 1400;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_char_code = 8'h00;
    logic                    s_end_of_input = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_kind;
    logic                    m_negative;
    logic [MANT_FIELD_W-1:0] m_mantissa;
    logic [4:0]              m_frac_digits;
    logic                    m_overflow;
    logic                    m_last;

    // parser state as predicted
    logic [1:0]  num_phase = PH_IDLE;
    logic        num_neg = 1'b0;
    logic [63:0] num_acc = 64'd0;
    logic [4:0]  num_frac = 5'd0;
    logic        num_sat = 1'b0;

    res_t expected_words[$];
    int   words_sent = 0;
    int   fail_count = 0;
    int   cycle_count = 0;
    bit   tx_gaps = 1'b1;
    bit   rx_gaps = 1'b1;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    decimal_text_to_number_unit #(
        .MANTISSA_BITS  (MANT_BITS),
        .MAX_FRAC_DIGITS(MAX_FRAC)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_input(s_end_of_input),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_negative    (m_negative),
        .m_mantissa    (m_mantissa),
        .m_frac_digits (m_frac_digits),
        .m_overflow    (m_overflow),
        .m_last        (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_number();
        num_phase = PH_IDLE;
        num_neg   = 1'b0;
        num_acc   = 64'd0;
        num_frac  = 5'd0;
        num_sat   = 1'b0;
    endfunction

    function automatic void add_word(kind_t k, logic neg, logic [63:0] man, logic [4:0] fr,
                                     logic ovf);
        res_t w;
        w.kind        = k;
        w.negative    = neg;
        w.mantissa    = man[MANT_FIELD_W-1:0];
        w.frac_digits = fr;
        w.overflow    = ovf;
        w.last        = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void flush_number();
        add_word(KIND_NUM, num_neg, num_acc, num_frac, num_sat);
        clear_number();
    endfunction

    function automatic void take_digit(logic [3:0] d);
        if (num_sat)
            return;
        if (num_phase == PH_FRAC && num_frac >= MAX_FRAC) begin
            num_sat = 1'b1;
            return;
        end
        if (num_acc > (MANT_MAX - 64'(d)) / 64'd10) begin
            num_acc = MANT_MAX;
            num_sat = 1'b1;
            return;
        end
        num_acc = num_acc * 64'd10 + 64'(d);
        if (num_phase == PH_FRAC)
            num_frac = num_frac + 5'd1;
    endfunction

    // advances the predicted parser by one accepted word and queues its results
    function automatic void parse_byte(logic [7:0] c, logic eoi);
        int  n_before;
        bit  active;
        bit  handled;
        n_before = expected_words.size();
        active = (num_phase == PH_INT || num_phase == PH_FRAC);
        handled = 1'b0;
        if (eoi) begin
            if (active)
                flush_number();
            add_word(KIND_END, 1'b0, 64'd0, 5'd0, 1'b0);
            clear_number();
        end else begin
            if (active) begin
                if (is_digit(c)) begin
                    take_digit(4'(c - CH_ZERO));
                    handled = 1'b1;
                end else if (num_phase == PH_INT && c == CH_POINT) begin
                    num_phase = PH_FRAC;
                    handled = 1'b1;
                end else begin
                    flush_number();
                end
            end
            if (!handled) begin
                clear_number();
                if (is_space(c)) begin
                end else if (is_digit(c)) begin
                    num_phase = PH_INT;
                    take_digit(4'(c - CH_ZERO));
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    num_phase = PH_INT;
                    num_neg = (c == CH_MINUS);
                end else if (c == CH_POINT) begin
                    num_phase = PH_FRAC;
                end else begin
                    add_word(KIND_NAN, 1'b0, 64'd0, 5'd0, 1'b0);
                end
            end
        end
        if (expected_words.size() > n_before)
            expected_words[expected_words.size()-1].last = 1'b1;
    endfunction

    task automatic send_word(input logic [7:0] c, input logic eoi);
        while (tx_gaps && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_code    <= c;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        parse_byte(c, eoi);
        words_sent++;
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_word();
        res_t e;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual kind %0d",
                     $time, m_kind);
            fail_count++;
            return;
        end
        e = expected_words.pop_front();
        check_field("kind", 64'(e.kind), 64'(m_kind));
        check_field("negative", 64'(e.negative), 64'(m_negative));
        check_field("mantissa", 64'(e.mantissa), 64'(m_mantissa));
        check_field("frac_digits", 64'(e.frac_digits), 64'(m_frac_digits));
        check_field("overflow", 64'(e.overflow), 64'(m_overflow));
        check_field("last", 64'(e.last), 64'(m_last));
    endtask

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !(rx_gaps && $urandom_range(0, 99) < 16);
        end
        if (aresetn && m_valid && m_ready)
            check_word();
    end

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] pick_other();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_space(c) || is_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_POINT);
        return c;
    endfunction

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++)
            send_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    // one well-formed number with random content and an optional random terminator
    task automatic send_random_number();
        string max_text;
        int    r;
        max_text = "1152921504606846975";
        repeat ($urandom_range(0, 2)) send_word(pick_space(), 1'b0);
        r = $urandom_range(0, 2);
        if (r == 1)
            send_word(CH_PLUS, 1'b0);
        else if (r == 2)
            send_word(CH_MINUS, 1'b0);
        r = $urandom_range(0, 19);
        if (r == 0) begin
            for (int i = 0; i < 18; i++)
                send_word(8'(max_text[i]), 1'b0);
            send_digits(1);
        end else if (r < 3) begin
            send_digits($urandom_range(17, 21));
        end else begin
            send_digits($urandom_range(0, 6));
        end
        if ($urandom_range(0, 1)) begin
            send_word(CH_POINT, 1'b0);
            if ($urandom_range(0, 9) == 0)
                send_digits($urandom_range(16, 21));
            else
                send_digits($urandom_range(0, 5));
        end
        case ($urandom_range(0, 6))
            0, 6: send_word(pick_space(), 1'b0);
            1: send_word($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
            2: send_word(CH_POINT, 1'b0);
            3: send_word(pick_other(), 1'b0);
            4: send_word(8'($urandom_range(0, 255)), 1'b1);
            default: ;
        endcase
    endtask

    task automatic test_whitespace();
        send_word(CH_TAB, 1'b0);
        send_word(8'h0A, 1'b0);
        send_word(8'h0B, 1'b0);
        send_word(8'h0C, 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(CH_SPACE, 1'b0);
    endtask

    task automatic test_signed_fraction();
        send_word(CH_MINUS, 1'b0);
        send_word(CH_ZERO, 1'b0);
        send_word(CH_POINT, 1'b0);
        send_word(CH_NINE, 1'b0);
        send_word(8'hFF, 1'b0);
    endtask

    task automatic test_bare_signs_and_points();
        send_word(CH_MINUS, 1'b0);
        send_word(CH_PLUS, 1'b0);
        send_word(CH_POINT, 1'b0);
        send_word(CH_POINT, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(CH_PLUS, 1'b0);
        send_word(CH_POINT, 1'b0);
        send_word(CH_SPACE, 1'b0);
    endtask

    task automatic test_end_of_input();
        send_word(CH_NINE, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
    endtask

    task automatic test_random_numbers(input int count);
        int target;
        target = words_sent + count;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        while (words_sent < target)
            send_random_number();
    endtask

    task automatic test_steady_stream(input int count);
        int target;
        target = words_sent + count;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        while (words_sent < target)
            send_random_number();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // receiver stalls long enough for both queues to fill and s_ready to drop
    task automatic test_backpressure(input int count);
        int target;
        target = words_sent + count;
        tx_gaps = 1'b0;
        hold_req <= hold_req + 1;
        while (words_sent < target)
            send_random_number();
        tx_gaps = 1'b1;
        wait_results();
    endtask

    task automatic test_noise(input int count);
        for (int i = 0; i < count; i++)
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_whitespace();
        test_signed_fraction();
        test_bare_signs_and_points();
        test_end_of_input();
        wait_results();
        test_random_numbers(600);
        test_steady_stream(300);
        test_backpressure(60);
        test_noise(150);
        test_random_numbers(TOTAL_WORDS - words_sent);
        wait_results();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* decimal_text_to_number_unit.f */
design/dtn_pkg.sv
design/dtn_front.sv
design/dtn_back.sv
design/decimal_text_to_number_unit.sv
tb/sv/tb_decimal_text_to_number_unit.sv
